/* rtl/core/spa_pkg.sv */
package spa_pkg;

  // Pool geometry. Slot numbers and list positions are SLOT_W bits wide and
  // counts need one more bit so that they can hold a full pool.
  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;

  // Pool size after reset.
  localparam logic [CNT_W-1:0] POOL_RESET = CNT_W'((MAX_SLOTS < 256) ? MAX_SLOTS : 256);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_NOT_LIVE  = 2'd2;
  localparam logic [1:0] STATUS_RANGE     = 2'd3;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_out;
    logic [CNT_W-1:0]  live_count;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

endpackage

/* rtl/core/spa_ram.sv */
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/slot_pool_allocator_top.sv */
// Slot pool allocator. Hands out and takes back slot numbers from a pool of
// pool_size slots (1 to 256, 256 after reset). An allocate request returns
// the slot on top of the free stack (slot 0 first after a refill, then the
// most recently freed slot), or status "exhausted" when none is left; a free
// request returns the slot to the pool, or reports that the slot is out of
// range or not currently allocated, leaving the state untouched. Every
// request produces exactly one response, which also carries the live and
// free counts after the request. In the accept cycle the free stack, the
// active list and the position memory are read; in the write-back state the
// response is formed and the updates are written back, and no new request is
// taken until the write-back completes. The write-back only completes once
// the output register is free, so a response held by out_stall stalls the
// write-back of the following request while it still waits.
// The response sits in an output register, so the next request is accepted
// while a response still waits on out_stall. Writing pool_size reinitializes
// the pool at once, with no clearing pass; it must only be written while no
// request is in flight. Sizes below 1 or above 256 are clamped.
module slot_pool_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  spa_pkg::req_t               in_req,

  output logic                        out_valid,
  input  logic                        out_stall,
  output spa_pkg::rsp_t               out_rsp,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spa_pkg::CNT_W-1:0]   cfg_data
);

  localparam int SW = spa_pkg::SLOT_W;
  localparam int CW = spa_pkg::CNT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Control state.
  logic          state_r, state_nxt;
  logic [CW-1:0] pool_size_r, pool_size_nxt;
  logic [CW-1:0] free_depth_r, free_depth_nxt;
  logic [CW-1:0] active_depth_r, active_depth_nxt;
  // Lowest free stack depth reached since the last refill. Stack entries
  // below it have never been overwritten and still hold their refill value,
  // which is computed rather than stored.
  logic [CW-1:0] low_water_r, low_water_nxt;
  // One live flag per slot, cleared together by reset or a pool size write.
  logic [spa_pkg::MAX_SLOTS-1:0] live_r, live_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Request held between the read and the write-back cycle.
  spa_pkg::req_t req_r;
  logic          fill_r;
  logic [SW-1:0] fill_val_r;
  spa_pkg::rsp_t out_rsp_r, rsp_c;

  logic          accept;
  logic          cfg_write;
  logic          done;
  logic [CW-1:0] top_idx;
  logic [CW-1:0] cfg_clamped;

  // Memory ports.
  logic          stk_we, act_we, pos_we;
  logic [SW-1:0] stk_waddr, act_waddr, pos_waddr;
  logic [SW-1:0] stk_wdata, act_wdata, pos_wdata;
  logic [SW-1:0] stk_raddr, act_raddr, pos_raddr;
  logic [SW-1:0] stk_rdata, act_rdata, pos_rdata;

  logic [SW-1:0] grant_slot;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The write-back cycle completes once the output register is free.
  assign done = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  // Reads are launched in the accept cycle: the stack top, the last active
  // entry and the position of the slot named by the request. No write is
  // ever issued in that cycle, so reads never collide with writes. While the
  // write-back cycle waits, the addresses hold so the read data stays valid;
  // the input port may already carry the next request by then, so the
  // position read follows the held request.
  assign top_idx   = free_depth_r - CW'(1);
  assign stk_raddr = top_idx[SW-1:0];
  assign act_raddr = SW'(active_depth_r - CW'(1));
  assign pos_raddr = (state_r == ST_EXEC) ? req_r.slot_in : in_req.slot_in;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = CW'(1);
    end else if (cfg_data > CW'(spa_pkg::MAX_SLOTS)) begin
      cfg_clamped = CW'(spa_pkg::MAX_SLOTS);
    end
  end

  assign grant_slot = fill_r ? fill_val_r : stk_rdata;

  always_comb begin
    state_nxt        = state_r;
    pool_size_nxt    = pool_size_r;
    free_depth_nxt   = free_depth_r;
    active_depth_nxt = active_depth_r;
    low_water_nxt    = low_water_r;
    live_nxt         = live_r;
    out_valid_nxt    = out_valid_r && out_stall;

    stk_we    = 1'b0;
    act_we    = 1'b0;
    pos_we    = 1'b0;
    stk_waddr = free_depth_r[SW-1:0];
    stk_wdata = req_r.slot_in;
    act_waddr = active_depth_r[SW-1:0];
    act_wdata = grant_slot;
    pos_waddr = grant_slot;
    pos_wdata = active_depth_r[SW-1:0];

    rsp_c            = '0;
    rsp_c.slot_out   = req_r.slot_in;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_r.command == spa_pkg::CMD_ALLOC) begin
          rsp_c.slot_out = '0;
          if (free_depth_r == '0 || active_depth_r >= CW'(spa_pkg::MAX_SLOTS)) begin
            rsp_c.status = spa_pkg::STATUS_EXHAUSTED;
          end else begin
            rsp_c.status     = spa_pkg::STATUS_OK;
            rsp_c.slot_out   = grant_slot;
            act_we           = done;
            pos_we           = done;
            free_depth_nxt   = free_depth_r - CW'(1);
            active_depth_nxt = active_depth_r + CW'(1);
            if (top_idx < low_water_r) begin
              low_water_nxt = top_idx;
            end
            live_nxt[grant_slot] = 1'b1;
          end
        end else begin
          if ({1'b0, req_r.slot_in} >= pool_size_r) begin
            rsp_c.status = spa_pkg::STATUS_RANGE;
          end else if (!live_r[req_r.slot_in] || active_depth_r == '0) begin
            rsp_c.status = spa_pkg::STATUS_NOT_LIVE;
          end else begin
            // Move the last active entry into the freed position. When the
            // freed slot is itself the last entry these writes are harmless.
            rsp_c.status     = spa_pkg::STATUS_OK;
            act_we           = done;
            act_waddr        = pos_rdata;
            act_wdata        = act_rdata;
            pos_we           = done;
            pos_waddr        = act_rdata;
            pos_wdata        = pos_rdata;
            active_depth_nxt = active_depth_r - CW'(1);
            live_nxt[req_r.slot_in] = 1'b0;
            if (free_depth_r < CW'(spa_pkg::MAX_SLOTS)) begin
              stk_we         = done;
              free_depth_nxt = free_depth_r + CW'(1);
            end
          end
        end
        rsp_c.live_count = active_depth_nxt;
        rsp_c.free_count = free_depth_nxt;

        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          free_depth_nxt   = free_depth_r;
          active_depth_nxt = active_depth_r;
          low_water_nxt    = low_water_r;
          live_nxt         = live_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A pool size write refills the free stack in descending order and
    // empties the active list.
    if (cfg_write) begin
      pool_size_nxt    = cfg_clamped;
      free_depth_nxt   = cfg_clamped;
      low_water_nxt    = cfg_clamped;
      active_depth_nxt = '0;
      live_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pool_size_r    <= spa_pkg::POOL_RESET;
      free_depth_r   <= spa_pkg::POOL_RESET;
      low_water_r    <= spa_pkg::POOL_RESET;
      active_depth_r <= '0;
      live_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pool_size_r    <= pool_size_nxt;
      free_depth_r   <= free_depth_nxt;
      low_water_r    <= low_water_nxt;
      active_depth_r <= active_depth_nxt;
      live_r         <= live_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_req;
      fill_r     <= (top_idx < low_water_r);
      fill_val_r <= SW'(pool_size_r - CW'(1) - top_idx);
    end
    if (done) begin
      out_rsp_r <= rsp_c;
    end
  end

  spa_ram #(.WIDTH(SW), .DEPTH(spa_pkg::MAX_SLOTS)) u_free_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  spa_ram #(.WIDTH(SW), .DEPTH(spa_pkg::MAX_SLOTS)) u_active_list (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  spa_ram #(.WIDTH(SW), .DEPTH(spa_pkg::MAX_SLOTS)) u_list_position (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

endmodule
